// ----- hw/rtl/irpc_pkg.sv -----
// Types and constants shared by the ink refill pump controller.
`default_nettype none

package irpc_pkg;

    typedef enum logic [1:0] {
        ACT_SCAN       = 2'd0,
        ACT_PUMP_TICK  = 2'd1,
        ACT_ALARM_TICK = 2'd2,
        ACT_RESET_KEY  = 2'd3
    } t_action;

    localparam int unsigned TICK_W     = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned RUN_W      = 4;
    localparam int unsigned BUZZ_W     = 6;
    localparam int unsigned PULSE_W    = 4;

    typedef logic [TICK_W-1:0]    t_ticks;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_cfg_index CFG_FILL_TIMEOUT  = 2'd0;
    localparam t_cfg_index CFG_OVERRUN_TICKS = 2'd1;

    localparam t_ticks FILL_TIMEOUT_RESET  = 16'd18000;
    localparam t_ticks OVERRUN_TICKS_RESET = 16'd3000;
    localparam t_ticks TICKS_MAX           = 16'hFFFF;

    localparam logic [PULSE_W-1:0] OVERFLOW_PULSE_LEN = 4'd10;

endpackage

`default_nettype wire

// ----- hw/rtl/ink_refill_pump_controller_core.sv -----
// Ink refill pump controller: float scans, fill timing, alarms and reset key.
// Results: the result of each accepted input transaction is loaded into the result register.
// Throughput: one transaction per cycle while the result is not stalled; the state
// update is a single pass of shallow per-channel logic between state and result registers.
// Reset: synchronous, active low; all channels armed, pumps and alarms off,
// registers at 18000 and 3000 pump ticks.
`default_nettype none

module ink_refill_pump_controller_core #(
    parameter int unsigned CHANNELS         = 4,
    parameter int unsigned OVERFLOW_SCANS   = 10,
    parameter int unsigned BUZZ_HALF_PERIOD = 50
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire irpc_pkg::t_cfg_index       i_cfg_index,
    input  wire irpc_pkg::t_ticks           i_cfg_data,

    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_action,
    input  wire logic [CHANNELS-1:0]        i_low_float_up,
    input  wire logic [CHANNELS-1:0]        i_high_float_up,

    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [CHANNELS-1:0]             o_pump_on,
    output logic                            o_ink_out_alarm,
    output logic                            o_overflow_pulse,
    output logic                            o_buzzer_drive,
    output logic [CHANNELS-1:0]             o_fill_warning
);

    import irpc_pkg::*;

    t_ticks r_fill_timeout;
    t_ticks r_overrun_ticks;

    logic [RUN_W-1:0]   r_high_run [CHANNELS];
    logic [RUN_W-1:0]   n_high_run [CHANNELS];
    t_ticks             r_fill_ticks [CHANNELS];
    t_ticks             n_fill_ticks [CHANNELS];
    t_ticks             r_overrun_cnt [CHANNELS];
    t_ticks             n_overrun_cnt [CHANNELS];
    logic [CHANNELS-1:0] r_armed, n_armed;
    logic [CHANNELS-1:0] r_filling, n_filling;
    logic [CHANNELS-1:0] r_in_overrun, n_in_overrun;
    logic [CHANNELS-1:0] r_warn, n_warn;
    logic [CHANNELS-1:0] r_pump, n_pump;

    logic               r_ink_out, n_ink_out;
    logic               r_buzz_req, n_buzz_req;
    logic               r_buzz_perm, n_buzz_perm;
    logic [BUZZ_W-1:0]  r_buzz_ticks, n_buzz_ticks;
    logic               r_buzz_phase, n_buzz_phase;
    logic               r_buzz_drive, n_buzz_drive;
    logic               r_ovf_pend, n_ovf_pend;
    logic               r_ovf_perm, n_ovf_perm;
    logic [PULSE_W-1:0] r_ovf_ticks, n_ovf_ticks;
    logic               r_ovf_drive, n_ovf_drive;

    logic                r_out_valid;
    logic [CHANNELS-1:0] r_out_pump;
    logic                r_out_ink;
    logic                r_out_ovf;
    logic                r_out_buzz;
    logic [CHANNELS-1:0] r_out_warn;

    logic   in_accept;
    t_ticks ticks_inc;
    logic   any_warn;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_high_run    = r_high_run;
        n_fill_ticks  = r_fill_ticks;
        n_overrun_cnt = r_overrun_cnt;
        n_armed       = r_armed;
        n_filling     = r_filling;
        n_in_overrun  = r_in_overrun;
        n_warn        = r_warn;
        n_pump        = r_pump;
        n_ink_out     = r_ink_out;
        n_buzz_req    = r_buzz_req;
        n_buzz_perm   = r_buzz_perm;
        n_buzz_ticks  = r_buzz_ticks;
        n_buzz_phase  = r_buzz_phase;
        n_buzz_drive  = r_buzz_drive;
        n_ovf_pend    = r_ovf_pend;
        n_ovf_perm    = r_ovf_perm;
        n_ovf_ticks   = r_ovf_ticks;
        n_ovf_drive   = r_ovf_drive;
        ticks_inc     = '0;
        any_warn      = |r_warn;

        unique case (t_action'(i_action))
            ACT_SCAN: begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (i_high_float_up[ch]) begin
                        n_high_run[ch] = r_high_run[ch] + RUN_W'(1);
                        if (n_high_run[ch] == RUN_W'(OVERFLOW_SCANS)) begin
                            n_ovf_pend     = 1'b1;
                            n_high_run[ch] = '0;
                        end
                    end else begin
                        n_high_run[ch] = '0;
                        if (r_armed[ch] && !i_low_float_up[ch]) begin
                            n_pump[ch]        = 1'b1;
                            n_armed[ch]       = 1'b0;
                            n_fill_ticks[ch]  = '0;
                            n_overrun_cnt[ch] = '0;
                            n_filling[ch]     = 1'b1;
                            n_in_overrun[ch]  = 1'b0;
                        end
                    end
                end
                if (any_warn) begin
                    n_ink_out    = 1'b1;
                    n_buzz_req   = 1'b1;
                    n_pump       = '0;
                    n_filling    = '0;
                    n_fill_ticks = '{default: '0};
                end
            end
            ACT_PUMP_TICK: begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    if (r_filling[ch]) begin
                        if (!r_in_overrun[ch]) begin
                            ticks_inc = (r_fill_ticks[ch] == TICKS_MAX) ?
                                        r_fill_ticks[ch] : r_fill_ticks[ch] + t_ticks'(1);
                            n_fill_ticks[ch] = ticks_inc;
                            if (i_low_float_up[ch]) begin
                                n_fill_ticks[ch] = '0;
                                n_in_overrun[ch] = 1'b1;
                            end else if (ticks_inc >= r_fill_timeout) begin
                                n_pump[ch]       = 1'b0;
                                n_filling[ch]    = 1'b0;
                                n_fill_ticks[ch] = '0;
                                n_warn[ch]       = 1'b1;
                            end
                        end else begin
                            ticks_inc = (r_overrun_cnt[ch] == TICKS_MAX) ?
                                        r_overrun_cnt[ch] : r_overrun_cnt[ch] + t_ticks'(1);
                            n_overrun_cnt[ch] = ticks_inc;
                            if (ticks_inc >= r_overrun_ticks) begin
                                n_pump[ch]        = 1'b0;
                                n_filling[ch]     = 1'b0;
                                n_in_overrun[ch]  = 1'b0;
                                n_overrun_cnt[ch] = '0;
                                n_armed[ch]       = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_ALARM_TICK: begin
                if (r_buzz_req && r_buzz_perm) begin
                    n_buzz_ticks = r_buzz_ticks + BUZZ_W'(1);
                    if (n_buzz_ticks == BUZZ_W'(BUZZ_HALF_PERIOD)) begin
                        n_buzz_ticks = '0;
                        n_buzz_phase = !r_buzz_phase;
                        n_buzz_drive = r_buzz_phase;
                    end
                end else begin
                    n_buzz_ticks = '0;
                end
                if (r_ovf_pend && r_ovf_perm) begin
                    n_ovf_ticks = r_ovf_ticks + PULSE_W'(1);
                    n_ovf_drive = 1'b1;
                    if (n_ovf_ticks == OVERFLOW_PULSE_LEN) begin
                        n_ovf_drive  = 1'b0;
                        n_ovf_pend   = 1'b0;
                        n_ovf_ticks  = '0;
                        n_ovf_perm   = 1'b0;
                        n_armed      = '0;
                        n_filling    = '0;
                        n_pump       = '0;
                        n_buzz_perm  = 1'b0;
                        n_buzz_drive = 1'b1;
                    end
                end
            end
            ACT_RESET_KEY: begin
                n_pump       = '0;
                n_armed      = '1;
                n_warn       = '0;
                n_buzz_drive = 1'b0;
                n_buzz_req   = 1'b0;
                n_buzz_perm  = 1'b1;
                n_ink_out    = 1'b0;
                n_ovf_pend   = 1'b0;
                n_ovf_ticks  = '0;
                n_ovf_perm   = 1'b1;
            end
            default: begin
                n_pump = r_pump;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_timeout  <= FILL_TIMEOUT_RESET;
            r_overrun_ticks <= OVERRUN_TICKS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_FILL_TIMEOUT) begin
                r_fill_timeout <= i_cfg_data;
            end else if (i_cfg_index == CFG_OVERRUN_TICKS) begin
                r_overrun_ticks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_run    <= '{default: '0};
            r_fill_ticks  <= '{default: '0};
            r_overrun_cnt <= '{default: '0};
            r_armed       <= '1;
            r_filling     <= '0;
            r_in_overrun  <= '0;
            r_warn        <= '0;
            r_pump        <= '0;
            r_ink_out     <= 1'b0;
            r_buzz_req    <= 1'b0;
            r_buzz_perm   <= 1'b1;
            r_buzz_ticks  <= '0;
            r_buzz_phase  <= 1'b0;
            r_buzz_drive  <= 1'b0;
            r_ovf_pend    <= 1'b0;
            r_ovf_perm    <= 1'b1;
            r_ovf_ticks   <= '0;
            r_ovf_drive   <= 1'b0;
        end else if (in_accept) begin
            r_high_run    <= n_high_run;
            r_fill_ticks  <= n_fill_ticks;
            r_overrun_cnt <= n_overrun_cnt;
            r_armed       <= n_armed;
            r_filling     <= n_filling;
            r_in_overrun  <= n_in_overrun;
            r_warn        <= n_warn;
            r_pump        <= n_pump;
            r_ink_out     <= n_ink_out;
            r_buzz_req    <= n_buzz_req;
            r_buzz_perm   <= n_buzz_perm;
            r_buzz_ticks  <= n_buzz_ticks;
            r_buzz_phase  <= n_buzz_phase;
            r_buzz_drive  <= n_buzz_drive;
            r_ovf_pend    <= n_ovf_pend;
            r_ovf_perm    <= n_ovf_perm;
            r_ovf_ticks   <= n_ovf_ticks;
            r_ovf_drive   <= n_ovf_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_pump <= n_pump;
            r_out_ink  <= n_ink_out;
            r_out_ovf  <= n_ovf_drive;
            r_out_buzz <= n_buzz_drive;
            r_out_warn <= n_warn;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pump_on        = r_out_pump;
    assign o_ink_out_alarm  = r_out_ink;
    assign o_overflow_pulse = r_out_ovf;
    assign o_buzzer_drive   = r_out_buzz;
    assign o_fill_warning   = r_out_warn;

    a_pump_not_warned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pump & r_warn) == '0)
        else $error("A channel with a latched warning is still pumping.");

    a_pulse_permitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf_drive |-> r_ovf_perm)
        else $error("Overflow pulse driven while overflow is locked out.");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("Input accepted while the result register is stalled.");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("Accepted transaction produced no result.");

endmodule

`default_nettype wire

// ----- tb/tb_ink_refill_pump_controller_core.sv -----
// Self-checking testbench for the ink refill pump controller core.
`default_nettype none

module tb_ink_refill_pump_controller_core;

    import irpc_pkg::*;

    localparam int N_CH       = 4;
    localparam int RUN_LIMIT  = 10;
    localparam int BUZZ_HALF  = 50;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [N_CH-1:0] pump_on;
        logic            ink_out;
        logic            overflow;
        logic            buzzer;
        logic [N_CH-1:0] warning;
    } t_pump_status;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    t_cfg_index       i_cfg_index = CFG_FILL_TIMEOUT;
    t_ticks           i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_action = ACT_SCAN;
    logic [N_CH-1:0]  i_low_float_up = '0;
    logic [N_CH-1:0]  i_high_float_up = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic [N_CH-1:0]  o_pump_on;
    logic             o_ink_out_alarm;
    logic             o_overflow_pulse;
    logic             o_buzzer_drive;
    logic [N_CH-1:0]  o_fill_warning;

    ink_refill_pump_controller_core #(
        .CHANNELS(N_CH),
        .OVERFLOW_SCANS(RUN_LIMIT),
        .BUZZ_HALF_PERIOD(BUZZ_HALF)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_action(i_action),
        .i_low_float_up(i_low_float_up),
        .i_high_float_up(i_high_float_up),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_pump_on(o_pump_on),
        .o_ink_out_alarm(o_ink_out_alarm),
        .o_overflow_pulse(o_overflow_pulse),
        .o_buzzer_drive(o_buzzer_drive),
        .o_fill_warning(o_fill_warning)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state of the controller.
    t_ticks          cfg_fill_timeout = FILL_TIMEOUT_RESET;
    t_ticks          cfg_overrun_len = OVERRUN_TICKS_RESET;
    logic [3:0]      run_cnt [N_CH];
    t_ticks          fill_cnt [N_CH];
    t_ticks          ovr_cnt [N_CH];
    logic [N_CH-1:0] armed = '1;
    logic [N_CH-1:0] fill_active = '0;
    logic [N_CH-1:0] overrun_active = '0;
    logic [N_CH-1:0] warn_lat = '0;
    logic [N_CH-1:0] pump_lat = '0;
    logic            ink_out = 1'b0;
    logic            buzz_req = 1'b0;
    logic            buzz_ok = 1'b1;
    logic [5:0]      buzz_cnt = '0;
    logic            buzz_ph = 1'b0;
    logic            buzz_out = 1'b0;
    logic            ovf_pend = 1'b0;
    logic            ovf_ok = 1'b1;
    logic [3:0]      ovf_cnt = '0;
    logic            ovf_out = 1'b0;

    t_pump_status expected_status_q [$];
    bit  steady = 1'b0;
    int  items_sent = 0;
    int  results_checked = 0;
    int  reg_writes = 0;
    int  fail_count = 0;
    int  ink_out_seen = 0;
    int  overflow_seen = 0;
    int  buzzer_seen = 0;
    int  idle_cycles = 0;

    initial begin
        for (int c = 0; c < N_CH; c++) begin
            run_cnt[c] = '0;
            fill_cnt[c] = '0;
            ovr_cnt[c] = '0;
        end
    end

    function automatic t_pump_status predict_pump_status(t_action act, logic [N_CH-1:0] low,
                                                         logic [N_CH-1:0] high);
        t_pump_status st;
        int c;
        case (act)
            ACT_SCAN: begin
                for (c = 0; c < N_CH; c++) begin
                    if (high[c]) begin
                        run_cnt[c] = run_cnt[c] + 1'b1;
                        if (run_cnt[c] == RUN_LIMIT) begin
                            ovf_pend = 1'b1;
                            run_cnt[c] = '0;
                        end
                    end else begin
                        run_cnt[c] = '0;
                        if (armed[c] && !low[c]) begin
                            pump_lat[c] = 1'b1;
                            armed[c] = 1'b0;
                            fill_cnt[c] = '0;
                            ovr_cnt[c] = '0;
                            fill_active[c] = 1'b1;
                            overrun_active[c] = 1'b0;
                        end
                    end
                end
                if (|warn_lat) begin
                    ink_out = 1'b1;
                    buzz_req = 1'b1;
                    pump_lat = '0;
                    fill_active = '0;
                    for (c = 0; c < N_CH; c++) fill_cnt[c] = '0;
                end
            end
            ACT_PUMP_TICK: begin
                for (c = 0; c < N_CH; c++) begin
                    if (fill_active[c] && !overrun_active[c]) begin
                        if (fill_cnt[c] != TICKS_MAX) fill_cnt[c] = fill_cnt[c] + 1'b1;
                        if (low[c]) begin
                            fill_cnt[c] = '0;
                            overrun_active[c] = 1'b1;
                        end else if (fill_cnt[c] >= cfg_fill_timeout) begin
                            pump_lat[c] = 1'b0;
                            fill_active[c] = 1'b0;
                            fill_cnt[c] = '0;
                            warn_lat[c] = 1'b1;
                        end
                    end else if (fill_active[c]) begin
                        if (ovr_cnt[c] != TICKS_MAX) ovr_cnt[c] = ovr_cnt[c] + 1'b1;
                        if (ovr_cnt[c] >= cfg_overrun_len) begin
                            pump_lat[c] = 1'b0;
                            fill_active[c] = 1'b0;
                            overrun_active[c] = 1'b0;
                            ovr_cnt[c] = '0;
                            armed[c] = 1'b1;
                        end
                    end
                end
            end
            ACT_ALARM_TICK: begin
                if (buzz_req && buzz_ok) begin
                    buzz_cnt = buzz_cnt + 1'b1;
                    if (buzz_cnt == BUZZ_HALF) begin
                        buzz_cnt = '0;
                        buzz_ph = !buzz_ph;
                        buzz_out = !buzz_ph;
                    end
                end else begin
                    buzz_cnt = '0;
                end
                if (ovf_pend && ovf_ok) begin
                    ovf_cnt = ovf_cnt + 1'b1;
                    ovf_out = 1'b1;
                    if (ovf_cnt == OVERFLOW_PULSE_LEN) begin
                        ovf_out = 1'b0;
                        ovf_pend = 1'b0;
                        ovf_cnt = '0;
                        ovf_ok = 1'b0;
                        armed = '0;
                        fill_active = '0;
                        pump_lat = '0;
                        buzz_ok = 1'b0;
                        buzz_out = 1'b1;
                    end
                end
            end
            default: begin
                pump_lat = '0;
                armed = '1;
                warn_lat = '0;
                buzz_out = 1'b0;
                buzz_req = 1'b0;
                buzz_ok = 1'b1;
                ink_out = 1'b0;
                ovf_pend = 1'b0;
                ovf_cnt = '0;
                ovf_ok = 1'b1;
            end
        endcase
        st.pump_on = pump_lat;
        st.ink_out = ink_out;
        st.overflow = ovf_out;
        st.buzzer = buzz_out;
        st.warning = warn_lat;
        return st;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [N_CH-1:0] rand_mask();
        return N_CH'($urandom);
    endfunction

    task automatic send_item(t_action act, logic [N_CH-1:0] low, logic [N_CH-1:0] high);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_low_float_up <= low;
        i_high_float_up <= high;
        do @(posedge i_clk); while (!o_in_ready);
        expected_status_q.push_back(predict_pump_status(act, low, high));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic await_idle();
        i_in_valid <= 1'b0;
        while (expected_status_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, t_ticks value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FILL_TIMEOUT) cfg_fill_timeout = value;
        else cfg_overrun_len = value;
        reg_writes++;
        @(negedge i_clk);
    endtask

    task automatic set_registers(t_ticks fill_limit, t_ticks overrun_len);
        await_idle();
        write_register(CFG_FILL_TIMEOUT, fill_limit);
        write_register(CFG_OVERRUN_TICKS, overrun_len);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_fill_cycle();
        int rise [N_CH];
        int span;
        int len;
        int r;
        int t;
        int c;
        logic [N_CH-1:0] low;
        span = (cfg_fill_timeout > 24) ? 24 : int'(cfg_fill_timeout) + 2;
        for (c = 0; c < N_CH; c++) rise[c] = $urandom_range(0, span);
        send_item(ACT_SCAN, rand_mask() & rand_mask(),
                  ($urandom_range(0, 5) == 0) ? rand_mask() : '0);
        len = $urandom_range(4, span + ((cfg_overrun_len > 12) ? 12 : cfg_overrun_len) + 4);
        for (t = 1; t <= len; t++) begin
            for (c = 0; c < N_CH; c++) low[c] = (t >= rise[c]);
            r = $urandom_range(0, 9);
            if (r < 7) send_item(ACT_PUMP_TICK, low, rand_mask());
            else if (r < 9) send_item(ACT_SCAN, low, '0);
            else send_item(ACT_ALARM_TICK, rand_mask(), rand_mask());
        end
    endtask

    task automatic run_overflow_build();
        logic [N_CH-1:0] held;
        int n;
        int k;
        held = N_CH'($urandom_range(1, 15));
        n = $urandom_range(RUN_LIMIT - 2, RUN_LIMIT + 3);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 11) == 0) send_item(ACT_SCAN, rand_mask(), held & rand_mask());
            else send_item(ACT_SCAN, rand_mask(), held | rand_mask());
        end
        n = $urandom_range(OVERFLOW_PULSE_LEN - 2, OVERFLOW_PULSE_LEN + 4);
        for (k = 0; k < n; k++) send_item(ACT_ALARM_TICK, rand_mask(), rand_mask());
        if ($urandom_range(0, 2) == 0) send_item(ACT_RESET_KEY, rand_mask(), rand_mask());
    endtask

    task automatic run_alarm_burst();
        int n;
        int k;
        n = $urandom_range(20, 110);
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0) send_item(ACT_SCAN, rand_mask(), rand_mask());
            else send_item(ACT_ALARM_TICK, rand_mask(), rand_mask());
        end
    endtask

    task automatic run_noise();
        int n;
        int k;
        n = $urandom_range(3, 10);
        for (k = 0; k < n; k++)
            send_item(t_action'($urandom_range(0, 3)), rand_mask(), rand_mask());
    endtask

    task automatic run_random_phase(int n_items, int w_fill, int w_ovf, int w_alarm,
                                    int w_noise);
        int stop_at;
        int pick;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, w_fill + w_ovf + w_alarm + w_noise - 1);
            if (pick < w_fill) run_fill_cycle();
            else if (pick < w_fill + w_ovf) run_overflow_build();
            else if (pick < w_fill + w_ovf + w_alarm) run_alarm_burst();
            else run_noise();
            if ($urandom_range(0, 5) == 0) send_item(ACT_RESET_KEY, rand_mask(), rand_mask());
        end
        steady = 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_item(ACT_SCAN, 4'b0000, 4'b0000);
        send_item(ACT_PUMP_TICK, 4'b0101, 4'b0000);
        send_item(ACT_PUMP_TICK, 4'b1111, 4'b1111);
        send_item(ACT_RESET_KEY, 4'b0000, 4'b0000);
    endtask

    task automatic test_zero_registers();
        set_registers('0, '0);
        send_item(ACT_SCAN, 4'b0000, 4'b0000);
        send_item(ACT_PUMP_TICK, 4'b0011, 4'b0000);
        send_item(ACT_PUMP_TICK, 4'b0011, 4'b0000);
        send_item(ACT_SCAN, 4'b1111, 4'b1111);
        send_item(ACT_ALARM_TICK, 4'b1010, 4'b0101);
        send_item(ACT_RESET_KEY, 4'b1111, 4'b1111);
    endtask

    task automatic test_extreme_registers();
        set_registers(TICKS_MAX, TICKS_MAX);
        send_item(ACT_SCAN, 4'b0000, 4'b0000);
        send_item(ACT_PUMP_TICK, 4'b0000, 4'b0000);
        send_item(ACT_PUMP_TICK, 4'b1111, 4'b0000);
        send_item(ACT_PUMP_TICK, 4'b1111, 4'b1111);
        send_item(ACT_SCAN, 4'b1111, 4'b0000);
        send_item(ACT_RESET_KEY, 4'b0000, 4'b0000);
    endtask

    task automatic test_fill_timing();
        set_registers(16'd6, 16'd3);
        run_random_phase(250, 6, 1, 2, 1);
    endtask

    task automatic test_overflow_lockout();
        set_registers(16'd1, 16'd1);
        run_random_phase(200, 2, 6, 2, 1);
    endtask

    task automatic test_buzzer_alarms();
        set_registers(16'd3, 16'd0);
        run_random_phase(200, 3, 1, 5, 1);
    endtask

    task automatic test_random_mix();
        set_registers(t_ticks'($urandom_range(1, 20)), t_ticks'($urandom_range(1, 12)));
        run_random_phase(200, 1, 1, 1, 3);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (!steady && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat (1 + pick_gap()) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_pump_status exp_st;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_status_q.size() == 0) begin
                $error("Result transaction arrived with no expected status pending");
                fail_count++;
            end else begin
                exp_st = expected_status_q.pop_front();
                results_checked++;
                if (exp_st.ink_out) ink_out_seen++;
                if (exp_st.overflow) overflow_seen++;
                if (exp_st.buzzer) buzzer_seen++;
                if (o_pump_on !== exp_st.pump_on) begin
                    $error("pump_on: expected %b, actual %b", exp_st.pump_on, o_pump_on);
                    fail_count++;
                end
                if (o_ink_out_alarm !== exp_st.ink_out) begin
                    $error("ink_out_alarm: expected %b, actual %b", exp_st.ink_out,
                           o_ink_out_alarm);
                    fail_count++;
                end
                if (o_overflow_pulse !== exp_st.overflow) begin
                    $error("overflow_pulse: expected %b, actual %b", exp_st.overflow,
                           o_overflow_pulse);
                    fail_count++;
                end
                if (o_buzzer_drive !== exp_st.buzzer) begin
                    $error("buzzer_drive: expected %b, actual %b", exp_st.buzzer,
                           o_buzzer_drive);
                    fail_count++;
                end
                if (o_fill_warning !== exp_st.warning) begin
                    $error("fill_warning: expected %b, actual %b", exp_st.warning,
                           o_fill_warning);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_status_q.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_zero_registers();
        test_extreme_registers();
        test_fill_timing();
        test_overflow_lockout();
        test_buzzer_alarms();
        test_random_mix();
        await_idle();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d input transactions with %0d register writes; checked %0d results.",
                 items_sent, reg_writes, results_checked);
        $display("Results with ink-out alarm: %0d, overflow pulse: %0d, buzzer sounding: %0d.",
                 ink_out_seen, overflow_seen, buzzer_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
